// ===== src/pam_pkg.sv =====
// ----------------------------------------------------------------------------
// pam_pkg
// Shared types and constants for the polynomial add/multiply block.
// ----------------------------------------------------------------------------
package pam_pkg;

  localparam int MAX_DEGREE = 31;
  localparam int NSLOT      = MAX_DEGREE + 1;
  localparam int NPROD      = 2 * MAX_DEGREE + 1;
  localparam int SLOT_W     = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int PROD_W     = (NPROD > 1) ? $clog2(NPROD) : 1;

  localparam int CMD_W      = 3;
  localparam int POWER_W    = 5;
  localparam int COEFF_W    = 16;
  localparam int TPOW_W     = 6;
  localparam int TCOEFF_W   = 48;

  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 3'd0,
    CMD_LOAD_B = 3'd1,
    CMD_SUM    = 3'd2,
    CMD_PROD   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EMPTY,
    BK_SUM,
    BK_PMAC,
    BK_PDRAIN,
    BK_PEMIT
  } back_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [POWER_W-1:0]        power;
    logic signed [COEFF_W-1:0] coeff;
  } in_beat_t;

  typedef struct packed {
    logic [TPOW_W-1:0]          term_power;
    logic signed [TCOEFF_W-1:0] term_coeff;
    logic                       last_term;
    logic                       no_terms;
  } out_beat_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [SLOT_W-1:0]         slot;
    logic signed [COEFF_W-1:0] coeff;
  } q_entry_t;

endpackage

// ===== src/pam_queue.sv =====
// ----------------------------------------------------------------------------
// pam_queue
// Short command queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
module pam_queue import pam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_data
);

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/pam_front.sv =====
// ----------------------------------------------------------------------------
// pam_front
// Input beat decode: drops unused commands and out-of-range loads, queues
// the rest as typed commands.
// ----------------------------------------------------------------------------
module pam_front import pam_pkg::*; (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  output logic     push_valid,
  input  logic     push_ready,
  output q_entry_t push_data
);

  logic is_load, keep;

  always_comb begin
    is_load = (in_data.command == CMD_LOAD_A) || (in_data.command == CMD_LOAD_B);
    keep    = (in_data.command <= CMD_CLEAR) &&
              (!is_load || (int'(in_data.power) <= MAX_DEGREE));
    push_data.cmd   = cmd_t'(in_data.command);
    push_data.slot  = in_data.power[SLOT_W-1:0];
    push_data.coeff = in_data.coeff;
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid && keep;

endmodule

// ===== src/pam_back.sv =====
// ----------------------------------------------------------------------------
// pam_back
// Execution back end: coefficient stores, sum walk, product multiply-
// accumulate per output power, and the output register.
// ----------------------------------------------------------------------------
module pam_back import pam_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  q_entry_t  pop_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NSLOT - 1);
  localparam logic [PROD_W-1:0] PROD_LAST = PROD_W'(NPROD - 1);

  function automatic logic signed [COEFF_W-1:0] sat16(input logic signed [COEFF_W:0] s);
    logic signed [COEFF_W-1:0] r;
    r = s[COEFF_W-1:0];
    if (s[COEFF_W] != s[COEFF_W-1]) begin
      r = s[COEFF_W] ? {1'b1, {(COEFF_W-1){1'b0}}} : {1'b0, {(COEFF_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] lowest_set(input logic [NSLOT-1:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int k = NSLOT - 1; k >= 0; k--) begin
      if (v[k]) begin
        r = SLOT_W'(k);
      end
    end
    return r;
  endfunction

  back_state_t state_r, state_nxt;

  logic signed [COEFF_W-1:0]  coef_a_r [NSLOT];
  logic signed [COEFF_W-1:0]  coef_b_r [NSLOT];
  logic [NSLOT-1:0]           pres_a_r, pres_a_nxt, pres_b_r, pres_b_nxt;

  logic [PROD_W-1:0]          p_r, p_nxt, min_sum_r, min_sum_nxt;
  logic [SLOT_W-1:0]          i_r, i_nxt;
  logic                       any_r, any_nxt, drain_r, drain_nxt;
  logic                       s1_v_r, s1_v_nxt, s2_v_r;
  logic signed [COEFF_W-1:0]  op_a_r, op_a_nxt, op_b_r, op_b_nxt;
  logic signed [2*COEFF_W-1:0] prod_r;
  logic signed [TCOEFF_W-1:0] acc_r, acc_nxt;

  logic                       out_valid_r, out_valid_nxt;
  out_beat_t                  out_data_r, out_data_nxt;
  logic                       out_free;

  logic [SLOT_W-1:0]          addr_a, addr_b, j;
  logic signed [COEFF_W-1:0]  rd_a, rd_b, wr_data;
  logic                       wr_a_en, wr_b_en;
  logic [PROD_W:0]            diff;
  logic                       j_ok, hit;
  logic [SLOT_W-1:0]          ps;
  logic [NSLOT-1:0]           pres_or, low_mask;
  logic signed [TCOEFF_W-1:0] va, vb;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    diff = {1'b0, p_r} - {{(PROD_W + 1 - SLOT_W){1'b0}}, i_r};
    j    = diff[SLOT_W-1:0];
    j_ok = !diff[PROD_W] && (diff[PROD_W-1:0] <= PROD_W'(MAX_DEGREE));
    ps   = p_r[SLOT_W-1:0];
    case (state_r)
      BK_PMAC: begin
        addr_a = i_r;
        addr_b = j;
      end
      BK_SUM: begin
        addr_a = ps;
        addr_b = ps;
      end
      default: begin
        addr_a = pop_data.slot;
        addr_b = pop_data.slot;
      end
    endcase
    rd_a     = coef_a_r[addr_a];
    rd_b     = coef_b_r[addr_b];
    hit      = pres_a_r[i_r] && pres_b_r[j] && j_ok;
    pres_or  = pres_a_r | pres_b_r;
    low_mask = (NSLOT'(1) << ps) - NSLOT'(1);
    va       = pres_a_r[ps] ? TCOEFF_W'(rd_a) : '0;
    vb       = pres_b_r[ps] ? TCOEFF_W'(rd_b) : '0;
  end

  always_comb begin
    state_nxt     = state_r;
    pres_a_nxt    = pres_a_r;
    pres_b_nxt    = pres_b_r;
    p_nxt         = p_r;
    i_nxt         = i_r;
    min_sum_nxt   = min_sum_r;
    any_nxt       = any_r;
    drain_nxt     = drain_r;
    s1_v_nxt      = 1'b0;
    op_a_nxt      = rd_a;
    op_b_nxt      = rd_b;
    acc_nxt       = s2_v_r ? acc_r + TCOEFF_W'(prod_r) : acc_r;
    wr_a_en       = 1'b0;
    wr_b_en       = 1'b0;
    wr_data       = pop_data.coeff;
    pop_ready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          case (pop_data.cmd)
            CMD_LOAD_A: begin
              wr_a_en = 1'b1;
              if (pres_a_r[pop_data.slot]) begin
                wr_data = sat16((COEFF_W+1)'(rd_a) + (COEFF_W+1)'(pop_data.coeff));
              end
              pres_a_nxt[pop_data.slot] = 1'b1;
            end
            CMD_LOAD_B: begin
              wr_b_en = 1'b1;
              if (pres_b_r[pop_data.slot]) begin
                wr_data = sat16((COEFF_W+1)'(rd_b) + (COEFF_W+1)'(pop_data.coeff));
              end
              pres_b_nxt[pop_data.slot] = 1'b1;
            end
            CMD_SUM: begin
              p_nxt     = PROD_W'(SLOT_LAST);
              state_nxt = (pres_or == '0) ? BK_EMPTY : BK_SUM;
            end
            CMD_PROD: begin
              p_nxt       = PROD_LAST;
              i_nxt       = '0;
              any_nxt     = 1'b0;
              acc_nxt     = '0;
              min_sum_nxt = PROD_W'(lowest_set(pres_a_r)) + PROD_W'(lowest_set(pres_b_r));
              state_nxt   = (pres_a_r == '0 || pres_b_r == '0) ? BK_EMPTY : BK_PMAC;
            end
            CMD_CLEAR: begin
              pres_a_nxt = '0;
              pres_b_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      BK_EMPTY: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.term_power = '0;
          out_data_nxt.term_coeff = '0;
          out_data_nxt.last_term  = 1'b1;
          out_data_nxt.no_terms   = 1'b1;
          state_nxt               = BK_IDLE;
        end
      end
      BK_SUM: begin
        if (!pres_or[ps]) begin
          p_nxt = p_r - 1'b1;
          if (ps == '0) begin
            state_nxt = BK_IDLE;
          end
        end else if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.term_power = TPOW_W'(p_r);
          out_data_nxt.term_coeff = va + vb;
          out_data_nxt.last_term  = ((pres_or & low_mask) == '0);
          out_data_nxt.no_terms   = 1'b0;
          p_nxt                   = p_r - 1'b1;
          if ((pres_or & low_mask) == '0) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      BK_PMAC: begin
        s1_v_nxt = hit;
        any_nxt  = any_r || hit;
        i_nxt    = i_r + 1'b1;
        if (i_r == SLOT_LAST) begin
          drain_nxt = 1'b0;
          state_nxt = BK_PDRAIN;
        end
      end
      BK_PDRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = BK_PEMIT;
        end
      end
      BK_PEMIT: begin
        if (!any_r) begin
          p_nxt     = p_r - 1'b1;
          i_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = BK_PMAC;
        end else if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.term_power = TPOW_W'(p_r);
          out_data_nxt.term_coeff = acc_r;
          out_data_nxt.last_term  = (p_r == min_sum_r);
          out_data_nxt.no_terms   = 1'b0;
          if (p_r == min_sum_r) begin
            state_nxt = BK_IDLE;
          end else begin
            p_nxt     = p_r - 1'b1;
            i_nxt     = '0;
            any_nxt   = 1'b0;
            acc_nxt   = '0;
            state_nxt = BK_PMAC;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pres_a_r    <= '0;
      pres_b_r    <= '0;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      any_r       <= 1'b0;
      drain_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pres_a_r    <= pres_a_nxt;
      pres_b_r    <= pres_b_nxt;
      out_valid_r <= out_valid_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s1_v_r;
      any_r       <= any_nxt;
      drain_r     <= drain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    i_r        <= i_nxt;
    min_sum_r  <= min_sum_nxt;
    op_a_r     <= op_a_nxt;
    op_b_r     <= op_b_nxt;
    prod_r     <= op_a_r * op_b_r;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    if (wr_a_en) begin
      coef_a_r[addr_a] <= wr_data;
    end
    if (wr_b_en) begin
      coef_b_r[addr_b] <= wr_data;
    end
  end

endmodule

// ===== src/polynomial_add_multiply.sv =====
// ----------------------------------------------------------------------------
// polynomial_add_multiply
// Two sparse polynomials, A and B, loaded term by term; emits A+B or A*B.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : command beats (load A, load B, emit sum, emit product, clear).
//           Unused commands and loads above the top power are dropped.
//   out_* : result beats, highest power first, last_term on the final beat;
//           an empty result is a single beat with no_terms and last_term set.
//   A four-entry command queue separates decode from execution, so input
//   beats queue up while an emit run is stalled on the output, up to its depth.
//   Loads and clears are done by the executor in its idle state, so one
//   input beat per cycle is sustained for loads while no emit run is ahead.
//   Emit sum walks 32 powers from the top down, one per cycle while the
//   output does not stall, and stops after the lowest present term.
//   Emit product runs, per output power from the top, one multiply-accumulate
//   pass over 32 slots of A, a pipeline drain and an emit step; powers with
//   no term are skipped. It covers up to 63 powers, stops after the lowest
//   one with a term, and an output stall holds the emit step.
//   Reset clears both polynomials, the queue and the output valid flag.
//   When out_ready is low a pending beat holds and the executor waits to emit.
// ----------------------------------------------------------------------------
module polynomial_add_multiply import pam_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic     push_valid, push_ready, pop_valid, pop_ready;
  q_entry_t push_data, pop_data;

  pam_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pam_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pam_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== dv/polynomial_add_multiply_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_add_multiply_test
// Self-checking bench for the polynomial add/multiply block. A local model of
// both coefficient stores predicts every result beat of the sum and product
// runs; the beats are checked field by field in order. Directed cases cover
// empty results, saturation at both ends, zero and cancelling coefficients,
// one-sided products and the top power. A back-pressure phase fills the
// command queue; then random load/emit sequences run with random idling.
// ----------------------------------------------------------------------------
module polynomial_add_multiply_test;
  import pam_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam int RANDOM_BEATS = 400;
  localparam int TAIL_CYCLES  = 100;
  localparam int CYCLE_LIMIT  = 4000000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  polynomial_add_multiply dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // local copy of both polynomials
  logic signed [COEFF_W-1:0] poly_a [NSLOT];
  logic signed [COEFF_W-1:0] poly_b [NSLOT];
  bit                        held_a [NSLOT];
  bit                        held_b [NSLOT];
  bit                        run_held [NPROD];
  longint                    run_val  [NPROD];

  out_beat_t expected_terms [$];
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  bit        tx_steady      = 1'b0;
  bit        rx_steady      = 1'b0;
  int        rx_hold_req    = 0;
  int        rx_hold_left   = 0;
  int        rx_stall_left  = 0;

  function automatic void clear_polys();
    for (int p = 0; p < NSLOT; p++) begin
      poly_a[p] = '0;
      poly_b[p] = '0;
      held_a[p] = 1'b0;
      held_b[p] = 1'b0;
    end
  endfunction

  function automatic void load_term(bit to_b, int p, int c);
    int  prev;
    int  s;
    bit  seen;
    if (p > MAX_DEGREE) return;
    seen = to_b ? held_b[p] : held_a[p];
    prev = to_b ? int'(poly_b[p]) : int'(poly_a[p]);
    s = seen ? prev + c : c;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    if (to_b) begin
      poly_b[p] = s[COEFF_W-1:0];
      held_b[p] = 1'b1;
    end else begin
      poly_a[p] = s[COEFF_W-1:0];
      held_a[p] = 1'b1;
    end
  endfunction

  // turns run_held/run_val into beats, highest power first
  function automatic void queue_run();
    int        lowest;
    out_beat_t t;
    lowest = -1;
    for (int p = NPROD - 1; p >= 0; p--)
      if (run_held[p]) lowest = p;
    t = '0;
    if (lowest < 0) begin
      t.last_term = 1'b1;
      t.no_terms  = 1'b1;
      expected_terms.push_back(t);
      return;
    end
    for (int p = NPROD - 1; p >= 0; p--) begin
      if (run_held[p]) begin
        t.term_power = p[TPOW_W-1:0];
        t.term_coeff = run_val[p][TCOEFF_W-1:0];
        t.last_term  = (p == lowest);
        t.no_terms   = 1'b0;
        expected_terms.push_back(t);
      end
    end
  endfunction

  function automatic void predict_terms(in_beat_t b);
    for (int p = 0; p < NPROD; p++) begin
      run_held[p] = 1'b0;
      run_val[p]  = 0;
    end
    case (b.command)
      CMD_LOAD_A: load_term(1'b0, int'(b.power), int'(b.coeff));
      CMD_LOAD_B: load_term(1'b1, int'(b.power), int'(b.coeff));
      CMD_SUM: begin
        for (int i = 0; i < NSLOT; i++) begin
          run_held[i] = held_a[i] | held_b[i];
          run_val[i]  = (held_a[i] ? longint'(poly_a[i]) : 0)
                      + (held_b[i] ? longint'(poly_b[i]) : 0);
        end
        queue_run();
      end
      CMD_PROD: begin
        for (int i = 0; i < NSLOT; i++)
          for (int j = 0; j < NSLOT; j++)
            if (held_a[i] && held_b[j]) begin
              run_held[i+j] = 1'b1;
              run_val[i+j] += longint'(poly_a[i]) * longint'(poly_b[j]);
            end
        queue_run();
      end
      CMD_CLEAR: clear_polys();
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    mismatch_count++;
    $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  task automatic send_beat(logic [CMD_W-1:0] command, logic [POWER_W-1:0] power,
                           logic signed [COEFF_W-1:0] coeff);
    int       gap;
    in_beat_t b;
    b.command = command;
    b.power   = power;
    b.coeff   = coeff;
    gap = tx_steady ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = b;
    do @(posedge clk); while (!in_ready);
    predict_terms(b);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    idle_input();
    while (expected_terms.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [COEFF_W-1:0] pick_coeff();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return 16'($signed($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  // result side: checker and stall counting
  always @(posedge clk) begin
    out_beat_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      if (expected_terms.size() == 0) begin
        report_mismatch("unexpected beat, power", out_data.term_power, -1);
      end else begin
        want = expected_terms.pop_front();
        if (out_data.term_power !== want.term_power)
          report_mismatch("term_power", out_data.term_power, want.term_power);
        if (out_data.term_coeff !== want.term_coeff)
          report_mismatch("term_coeff", longint'(out_data.term_coeff),
                          longint'(want.term_coeff));
        if (out_data.last_term !== want.last_term)
          report_mismatch("last_term", out_data.last_term, want.last_term);
        if (out_data.no_terms !== want.no_terms)
          report_mismatch("no_terms", out_data.no_terms, want.no_terms);
      end
      rx_stall_left = rx_steady ? 0 : $urandom_range(0, 8);
    end
  end

  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      out_ready = 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      out_ready = 1'b0;
      rx_stall_left--;
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic test_empty_results();
    send_beat(CMD_SUM, 5'd0, '0);
    send_beat(CMD_PROD, 5'd31, '0);
    send_beat(CMD_CLEAR, 5'd0, '0);
    send_beat(CMD_SPARE_FIRST, 5'($urandom), 16'($urandom));
    send_beat(CMD_SPARE_LAST, 5'($urandom), 16'($urandom));
    send_beat(CMD_SUM, 5'd31, 16'sh7FFF);
  endtask

  task automatic test_extreme_terms();
    send_beat(CMD_LOAD_A, 5'd0, 16'sh7FFF);
    send_beat(CMD_LOAD_A, 5'd0, 16'sh0001);
    send_beat(CMD_LOAD_A, 5'd31, 16'sh8000);
    send_beat(CMD_LOAD_A, 5'd31, 16'shFFFF);
    send_beat(CMD_LOAD_B, 5'd31, 16'sh8000);
    send_beat(CMD_LOAD_B, 5'd0, 16'sh8000);
    send_beat(CMD_LOAD_B, 5'd17, 16'sh0000);
    send_beat(CMD_SUM, 5'd0, '0);
    send_beat(CMD_PROD, 5'd0, '0);
  endtask

  task automatic test_one_sided_and_cancel();
    send_beat(CMD_CLEAR, 5'd0, '0);
    send_beat(CMD_LOAD_A, 5'd3, 16'sh1234);
    send_beat(CMD_PROD, 5'd0, '0);
    send_beat(CMD_SUM, 5'd0, '0);
    send_beat(CMD_LOAD_B, 5'd3, -16'sh1234);
    send_beat(CMD_SUM, 5'd0, '0);
    send_beat(CMD_PROD, 5'd0, '0);
  endtask

  task automatic test_back_pressure();
    wait_drained();
    tx_steady   = 1'b1;
    rx_hold_req = 600;
    send_beat(CMD_PROD, 5'd0, '0);
    for (int k = 0; k < 6; k++)
      send_beat($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
                5'($urandom), pick_coeff());
    send_beat(CMD_SUM, 5'd0, '0);
    send_beat(CMD_PROD, 5'd0, '0);
    wait_drained();
    tx_steady = 1'b0;
  endtask

  task automatic test_random_sequences();
    int                  beats;
    int                  loads;
    logic [POWER_W-1:0]  last_power;
    beats      = 0;
    last_power = '0;
    while (beats < RANDOM_BEATS) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        send_beat(CMD_CLEAR, 5'($urandom), 16'($urandom));
        beats++;
      end
      loads = $urandom_range(0, 10);
      for (int k = 0; k < loads; k++) begin
        if ($urandom_range(0, 3) != 0) last_power = 5'($urandom);
        send_beat($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A, last_power,
                  pick_coeff());
        beats++;
        if ($urandom_range(0, 11) == 0)
          send_beat(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                    5'($urandom), 16'($urandom));
      end
      case ($urandom_range(0, 2))
        0: send_beat(CMD_SUM, 5'($urandom), 16'($urandom));
        1: send_beat(CMD_PROD, 5'($urandom), 16'($urandom));
        default: begin
          send_beat(CMD_SUM, 5'($urandom), 16'($urandom));
          send_beat(CMD_PROD, 5'($urandom), 16'($urandom));
          beats++;
        end
      endcase
      beats++;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    clear_polys();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_empty_results();
    test_extreme_terms();
    test_one_sided_and_cancel();
    test_back_pressure();
    test_random_sequences();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_terms.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
